// ===== sv/auto_ranging_rms_level_meter_assert.svh =====
// Assertion macros for the auto-ranging RMS level meter.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef AUTO_RANGING_RMS_LEVEL_METER_ASSERT_SVH
`define AUTO_RANGING_RMS_LEVEL_METER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held
`define ARMS_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("arms assertion failed");
// Next-cycle implication, disabled while reset is held
`define ARMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("arms assertion failed");
`else
`define ARMS_ASSERT(lbl, clk, rstn, ante, cons)
`define ARMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/arms_pkg.sv =====
// Shared widths and constants of the auto-ranging RMS level meter.
// No dependencies; the interfaces, modules and testbench refer to it by scoped names.
package arms_pkg;

  // Sample path
  localparam int SMP_W  = 16;
  localparam int MAG_W  = SMP_W + 1;
  localparam int PROD_W = 2 * (SMP_W - 1) + 1;

  // Chunk accumulation
  localparam int SUM_W             = 44;
  localparam int MAX_CHUNK_SAMPLES = 8192;
  localparam int CNT_W             = $clog2(MAX_CHUNK_SAMPLES + 1);

  // Mean in Q.16, root in Q.8
  localparam int FRAC_W = 16;
  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int MEAN_W = PROD_W + FRAC_W;
  localparam int RAD_W  = MEAN_W + (MEAN_W % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int RMS_W  = 23;
  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  // Level quantizer
  localparam int LEVEL_COUNT = 6;
  localparam int LVL_STEPS   = LEVEL_COUNT - 1;
  localparam int LVL_W       = 3;
  localparam int NUM_W       = RMS_W + $clog2(2 * LVL_STEPS) + 1;

  // Silence timeout
  localparam int LIM_W = 16;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd3000;

endpackage

// ===== sv/arms_in_if.sv =====
// Input channel of the level meter: valid/ready with opcode, sample, chunk_last.
// Depends on arms_pkg for the field widths.
interface arms_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [arms_pkg::SMP_W-1:0] sample;
  logic                              chunk_last;

  modport source (output valid, output opcode, output sample, output chunk_last,
                  input ready);
  modport sink   (input valid, input opcode, input sample, input chunk_last,
                  output ready);
endinterface

// ===== sv/arms_out_if.sv =====
// Result channel of the level meter: valid/ready with level, rms_value, range_cleared.
// Depends on arms_pkg for the field widths.
interface arms_out_if;
  logic                       valid;
  logic                       ready;
  logic [arms_pkg::LVL_W-1:0] level;
  logic [arms_pkg::RMS_W-1:0] rms_value;
  logic                       range_cleared;

  modport source (output valid, output level, output rms_value, output range_cleared,
                  input ready);
  modport sink   (input valid, input level, input rms_value, input range_cleared,
                  output ready);
endinterface

// ===== sv/auto_ranging_rms_level_meter.sv =====
// Top level of the auto-ranging RMS level meter: sequencer, range tracking, output register.
// Depends on arms_pkg, arms_in_if, arms_out_if, arms_sq, arms_div, arms_sqrt, arms_lvl.
//
// Usage: the in_ch channel carries items with opcode 0 (audio sample) or 1 (time tick).
// Samples are squared and summed per chunk; the sample with chunk_last set closes the
// chunk and yields one result on out_ch: the chunk RMS in Q15.8, a level 0..5 mapped
// between the tracked minimum and maximum RMS, and a flag telling that the silence
// timeout cleared that range. cfg_we/cfg_wdata set the idle tick limit; write it only
// while the block is idle.
// Work per item: a tick only counts up the idle counter. A sample is accepted, squared
// by the bit-serial squarer (17 multiplier bits) and accumulated. A chunk-ending
// sample then passes, before its result is shown, through the divider (60 quotient
// bits, one per step) and the square root (24 root bits, two radicand bits each),
// plus 5 level steps that are skipped when there is no range to map onto.
// in_ch.ready is high only while no item is in work. The result sits in an output
// register, so a stalled receiver blocks nothing until the next result is ready to
// load; that one then waits in its final state until the register frees.
// Reset (synchronous, active low) clears the sum, count, range and idle counter and
// sets the limit to 3000 ticks.
`include "auto_ranging_rms_level_meter_assert.svh"

module auto_ranging_rms_level_meter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [arms_pkg::LIM_W-1:0] cfg_wdata,
  arms_in_if.sink                    in_ch,
  arms_out_if.source                 out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_DIV0 = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_RNG  = 4'd5;
  localparam logic [3:0] S_LVL0 = 4'd6;
  localparam logic [3:0] S_LVL  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]                  state_r;
  logic [3:0]                  state_nxt;
  logic [arms_pkg::LIM_W-1:0]  limit_r;
  logic [arms_pkg::LIM_W-1:0]  idle_r;
  logic [arms_pkg::SUM_W-1:0]  sum_r;
  logic [arms_pkg::CNT_W-1:0]  count_r;
  logic                        last_r;
  logic [arms_pkg::RMS_W-1:0]  rms_r;
  logic [arms_pkg::RMS_W-1:0]  min_r;
  logic [arms_pkg::RMS_W-1:0]  max_r;
  logic                        min_valid_r;
  logic                        cleared_r;
  logic                        out_valid_r;
  logic [arms_pkg::LVL_W-1:0]  out_level_r;
  logic [arms_pkg::RMS_W-1:0]  out_rms_r;
  logic                        out_clr_r;

  logic                        in_acc;
  logic                        room;
  logic [arms_pkg::MAG_W-1:0]  sx;
  logic [arms_pkg::MAG_W-1:0]  mag;
  logic                        sq_start;
  logic                        sq_done;
  logic [arms_pkg::PROD_W-1:0] prod;
  logic                        div_start;
  logic                        div_done;
  logic [arms_pkg::MEAN_W-1:0] mean;
  logic                        sqrt_start;
  logic                        sqrt_done;
  logic [arms_pkg::ROOT_W-1:0] root;
  logic [arms_pkg::RMS_W-1:0]  root_sat;
  logic                        lvl_start;
  logic                        lvl_done;
  logic [arms_pkg::LVL_W-1:0]  level;
  logic                        out_free;
  logic                        upd_min;
  logic                        clear;

  // Handshake and sample magnitude
  always_comb begin
    in_acc   = in_ch.valid && (state_r == S_IDLE);
    room     = count_r < arms_pkg::CNT_W'(arms_pkg::MAX_CHUNK_SAMPLES);
    sx       = {in_ch.sample[arms_pkg::SMP_W-1], in_ch.sample};
    mag      = sx[arms_pkg::MAG_W-1] ? (~sx + arms_pkg::MAG_W'(1)) : sx;
    out_free = !out_valid_r || out_ch.ready;
    root_sat = (root > arms_pkg::ROOT_W'(arms_pkg::RMS_MAX)) ? arms_pkg::RMS_MAX
                                                             : root[arms_pkg::RMS_W-1:0];
    upd_min  = !min_valid_r || (rms_r < min_r);
    clear    = idle_r > limit_r;
  end

  assign sq_start   = in_acc && !in_ch.opcode && room;
  assign div_start  = (state_r == S_DIV0);
  assign sqrt_start = (state_r == S_DIV) && div_done;
  assign lvl_start  = (state_r == S_LVL0);

  // Serial arithmetic units
  arms_sq u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .mag   (mag),
    .done  (sq_done),
    .prod  (prod)
  );

  arms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, arms_pkg::FRAC_W'(0)}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (mean)
  );

  arms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (arms_pkg::RAD_W'(mean)),
    .done     (sqrt_done),
    .root     (root)
  );

  arms_lvl u_lvl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lvl_start),
    .rms       (rms_r),
    .min_rms   (min_r),
    .max_rms   (max_r),
    .min_valid (min_valid_r),
    .done      (lvl_done),
    .level     (level)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !in_ch.opcode) begin
          if (room) begin
            state_nxt = S_SQ;
          end else if (in_ch.chunk_last) begin
            state_nxt = S_DIV0;
          end
        end
      end
      S_SQ: begin
        if (sq_done) begin
          state_nxt = last_r ? S_DIV0 : S_IDLE;
        end
      end
      S_DIV0: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          state_nxt = S_RNG;
        end
      end
      S_RNG:  state_nxt = S_LVL0;
      S_LVL0: state_nxt = S_LVL;
      S_LVL: begin
        if (lvl_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and chunk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= arms_pkg::LIMIT_RESET;
      idle_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      min_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // Count ticks, holding at full scale
      if (in_acc && in_ch.opcode && (idle_r != '1)) begin
        idle_r <= idle_r + arms_pkg::LIM_W'(1);
      end
      // Accumulate a finished square
      if ((state_r == S_SQ) && sq_done) begin
        sum_r   <= sum_r + arms_pkg::SUM_W'(prod);
        count_r <= count_r + arms_pkg::CNT_W'(1);
      end
      // Drop the chunk once the mean is taken
      if ((state_r == S_DIV) && div_done) begin
        sum_r   <= '0;
        count_r <= '0;
      end
      // Track the range, clear it after a long silence
      if (state_r == S_RNG) begin
        idle_r <= '0;
        if (clear) begin
          min_r       <= '0;
          max_r       <= '0;
          min_valid_r <= 1'b0;
        end else begin
          if (upd_min) begin
            min_r       <= rms_r;
            min_valid_r <= 1'b1;
          end
          if (rms_r > max_r) begin
            max_r <= rms_r;
          end
        end
      end
      // Output register valid
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc && !in_ch.opcode) begin
      last_r <= in_ch.chunk_last;
    end
    if ((state_r == S_SQRT) && sqrt_done) begin
      rms_r <= root_sat;
    end
    if (state_r == S_RNG) begin
      cleared_r <= clear;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_level_r <= level;
      out_rms_r   <= rms_r;
      out_clr_r   <= cleared_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.level         = out_level_r;
  assign out_ch.rms_value     = out_rms_r;
  assign out_ch.range_cleared = out_clr_r;

  // Checks
  `ARMS_ASSERT(a_lvl_bound, clk, rst_n, out_valid_r, 32'(out_level_r) < arms_pkg::LEVEL_COUNT)
  `ARMS_ASSERT(a_clr_lvl, clk, rst_n, out_valid_r && out_clr_r, out_level_r == '0)
  `ARMS_ASSERT(a_min_max, clk, rst_n, min_valid_r, min_r <= max_r)
  `ARMS_ASSERT(a_sum_drop, clk, rst_n, state_r == S_SQRT, (sum_r == '0) && (count_r == '0))
  `ARMS_ASSERT_NEXT(a_end_busy, clk, rst_n, in_acc && !in_ch.opcode && in_ch.chunk_last, state_r != S_IDLE)
endmodule

// ===== sv/arms_sq.sv =====
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add.
// Depends on arms_pkg.
module arms_sq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [arms_pkg::MAG_W-1:0]  mag,
  output logic                        done,
  output logic [arms_pkg::PROD_W-1:0] prod
);
  localparam int STEP_W = $clog2(arms_pkg::MAG_W);
  localparam int P_W    = 2 * arms_pkg::MAG_W;

  logic                       busy_r;
  logic                       done_r;
  logic [STEP_W-1:0]          step_r;
  logic [P_W-1:0]             prod_r;
  logic [arms_pkg::MAG_W-1:0] mcand_r;
  logic [arms_pkg::MAG_W:0]   psum;

  // Add the multiplicand to the upper half when the current multiplier bit is set
  always_comb begin
    psum = {1'b0, prod_r[P_W-1 -: arms_pkg::MAG_W]}
         + (prod_r[0] ? {1'b0, mcand_r} : '0);
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(arms_pkg::MAG_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Product shift register, multiplier bits in the lower half
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {arms_pkg::MAG_W'(0), mag};
      mcand_r <= mag;
    end else if (busy_r) begin
      prod_r <= {psum, prod_r[arms_pkg::MAG_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = prod_r[arms_pkg::PROD_W-1:0];
endmodule

// ===== sv/arms_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on arms_pkg; divides the scaled square sum by the sample count.
module arms_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [arms_pkg::DVD_W-1:0]  dividend,
  input  logic [arms_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [arms_pkg::MEAN_W-1:0] quotient
);
  localparam int STEP_W = $clog2(arms_pkg::DVD_W);

  logic                       busy_r;
  logic                       done_r;
  logic [STEP_W-1:0]          step_r;
  logic [arms_pkg::DVD_W-1:0] dq_r;
  logic [arms_pkg::CNT_W-1:0] dvs_r;
  logic [arms_pkg::CNT_W-1:0] rem_r;
  logic [arms_pkg::CNT_W:0]   trial;
  logic                       ge;
  logic [arms_pkg::CNT_W-1:0] rem_nxt;

  // Bring down the next dividend bit and try the subtract
  always_comb begin
    trial   = {rem_r, dq_r[arms_pkg::DVD_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? arms_pkg::CNT_W'(trial - {1'b0, dvs_r})
                 : trial[arms_pkg::CNT_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(arms_pkg::DVD_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[arms_pkg::DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  // Upper quotient bits are zero since each square is below 2^(2*SMP_W-1)
  assign done     = done_r;
  assign quotient = dq_r[arms_pkg::MEAN_W-1:0];
endmodule

// ===== sv/arms_sqrt.sv =====
// Digit-serial integer square root: two radicand bits per cycle.
// Depends on arms_pkg.
module arms_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [arms_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [arms_pkg::ROOT_W-1:0] root
);
  localparam int STEP_W = $clog2(arms_pkg::ROOT_W);
  localparam int REM_W  = arms_pkg::ROOT_W + 2;
  localparam int T_W    = REM_W + 2;

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [arms_pkg::RAD_W-1:0]  rad_r;
  logic [arms_pkg::ROOT_W-1:0] root_r;
  logic [REM_W-1:0]            rem_r;
  logic [T_W-1:0]              tval;
  logic [T_W-1:0]              trial;
  logic                        ge;

  // Append the next radicand pair and compare with 4*root+1
  always_comb begin
    tval  = {rem_r, rad_r[arms_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    ge    = tval >= trial;
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(arms_pkg::ROOT_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Root, remainder and radicand shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[arms_pkg::RAD_W-3:0], 2'b00};
      root_r <= {root_r[arms_pkg::ROOT_W-2:0], ge};
      rem_r  <= ge ? REM_W'(tval - trial) : tval[REM_W-1:0];
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ===== sv/arms_lvl.sv =====
// Serial level quantizer: compares the scaled offset against one threshold a cycle.
// Depends on arms_pkg; counts thresholds of (2k)*span passed by 2*(N-1)*d+span.
module arms_lvl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [arms_pkg::RMS_W-1:0] rms,
  input  logic [arms_pkg::RMS_W-1:0] min_rms,
  input  logic [arms_pkg::RMS_W-1:0] max_rms,
  input  logic                       min_valid,
  output logic                       done,
  output logic [arms_pkg::LVL_W-1:0] level
);
  localparam int STEP_W = $clog2(arms_pkg::LVL_STEPS + 1);

  logic                       busy_r;
  logic                       done_r;
  logic [STEP_W-1:0]          step_r;
  logic [arms_pkg::NUM_W-1:0] num_r;
  logic [arms_pkg::NUM_W-1:0] thr_r;
  logic [arms_pkg::NUM_W-1:0] span2_r;
  logic [arms_pkg::LVL_W-1:0] level_r;
  logic                       has_range;
  logic [arms_pkg::RMS_W-1:0] diff;
  logic [arms_pkg::RMS_W-1:0] span;
  logic [arms_pkg::NUM_W-1:0] num_init;

  // Range check and the rounding numerator
  always_comb begin
    has_range = (max_rms != '0) && min_valid && (max_rms > min_rms) && (rms >= min_rms);
    diff      = rms - min_rms;
    span      = max_rms - min_rms;
    num_init  = arms_pkg::NUM_W'(diff) * arms_pkg::NUM_W'(2 * arms_pkg::LVL_STEPS)
              + arms_pkg::NUM_W'(span);
  end

  // Sequence control; no range finishes at once with level zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= has_range;
        done_r <= !has_range;
        step_r <= STEP_W'(arms_pkg::LVL_STEPS - 1);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Step the threshold and count the ones passed
  always_ff @(posedge clk) begin
    if (start) begin
      num_r   <= num_init;
      span2_r <= arms_pkg::NUM_W'(span) << 1;
      thr_r   <= arms_pkg::NUM_W'(span) << 1;
      level_r <= '0;
    end else if (busy_r) begin
      thr_r <= thr_r + span2_r;
      if (num_r >= thr_r) begin
        level_r <= level_r + arms_pkg::LVL_W'(1);
      end
    end
  end

  assign done  = done_r;
  assign level = level_r;
endmodule

// ===== tb/tb_auto_ranging_rms_level_meter.sv =====
`timescale 1ns / 100ps
// Testbench for the auto-ranging RMS level meter: directed and random sample/tick items.
// A scoreboard class predicts every chunk result and checks it field by field.
// Depends on arms_pkg, arms_in_if, arms_out_if and auto_ranging_rms_level_meter.
module tb_auto_ranging_rms_level_meter;

  localparam bit OP_SAMPLE     = 1'b0;
  localparam bit OP_TICK       = 1'b1;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int FULL_CHUNK    = arms_pkg::MAX_CHUNK_SAMPLES + 3;
  localparam int TICK_BURST    = 65600;

  typedef struct {
    logic [arms_pkg::LVL_W-1:0] level;
    logic [arms_pkg::RMS_W-1:0] rms_value;
    logic                       range_cleared;
  } meter_result_t;

  // Predicts chunk results and checks them in order
  class rms_meter_scoreboard;
    logic [arms_pkg::LIM_W-1:0] silence_limit;
    logic [arms_pkg::SUM_W-1:0] square_acc;
    int unsigned                chunk_len;
    logic [arms_pkg::RMS_W:0]   rms_floor;
    logic [arms_pkg::RMS_W:0]   rms_ceil;
    bit                         floor_valid;
    logic [15:0]                idle_count;
    meter_result_t              expected_q[$];
    int                         errors;
    int                         results_checked;
    int                         clears_seen;
    int                         saturated_seen;
    int                         level_hits[8];

    function new();
      silence_limit   = arms_pkg::LIMIT_RESET;
      square_acc      = '0;
      chunk_len       = 0;
      rms_floor       = '0;
      rms_ceil        = '0;
      floor_valid     = 1'b0;
      idle_count      = '0;
      errors          = 0;
      results_checked = 0;
      clears_seen     = 0;
      saturated_seen  = 0;
      foreach (level_hits[i]) level_hits[i] = 0;
    endfunction

    // Floor of the square root, one result bit at a time from the top
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    // Advance the predicted state by one accepted item
    function void note_item(bit op, logic signed [15:0] smp, bit last);
      int                       sv;
      longint unsigned          mag;
      longint unsigned          mean;
      longint unsigned          root;
      longint unsigned          num;
      longint unsigned          den;
      longint unsigned          q;
      logic [arms_pkg::RMS_W:0] rms;
      logic [arms_pkg::RMS_W:0] span;
      meter_result_t            res;
      if (op == OP_TICK) begin
        if (idle_count != 16'hFFFF) idle_count++;
        return;
      end
      // Drop samples past the chunk capacity
      if (chunk_len < arms_pkg::MAX_CHUNK_SAMPLES) begin
        sv = smp;
        mag = (sv < 0) ? -sv : sv;
        square_acc += mag * mag;
        chunk_len++;
      end
      if (!last) return;
      if (chunk_len == 0) begin
        square_acc = '0;
        return;
      end
      mean = (64'(square_acc) << 16) / chunk_len;
      root = root_floor(mean);
      if (root > arms_pkg::RMS_MAX) begin
        rms = arms_pkg::RMS_MAX;
        saturated_seen++;
      end else begin
        rms = root[arms_pkg::RMS_W:0];
      end
      square_acc = '0;
      chunk_len  = 0;
      // Track the range, then clear it on a long silence
      if (!floor_valid || rms < rms_floor) begin
        rms_floor   = rms;
        floor_valid = 1'b1;
      end
      if (rms > rms_ceil) rms_ceil = rms;
      res.range_cleared = 1'b0;
      if (idle_count > silence_limit) begin
        rms_ceil          = '0;
        rms_floor         = '0;
        floor_valid       = 1'b0;
        res.range_cleared = 1'b1;
      end
      idle_count = '0;
      // Map onto the levels, rounding half up, clamped to the top level
      res.level = '0;
      if (rms_ceil != 0 && floor_valid && rms_ceil > rms_floor && rms >= rms_floor) begin
        span = rms_ceil - rms_floor;
        num  = 64'(rms - rms_floor) * 2 * arms_pkg::LVL_STEPS + 64'(span);
        den  = 2 * 64'(span);
        q    = num / den;
        if (q > arms_pkg::LVL_STEPS) q = arms_pkg::LVL_STEPS;
        res.level = q[arms_pkg::LVL_W-1:0];
      end
      res.rms_value = rms[arms_pkg::RMS_W-1:0];
      expected_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(logic [arms_pkg::LVL_W-1:0] lvl, logic [arms_pkg::RMS_W-1:0] rms,
                      logic clr);
      meter_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result with none pending: level=%0d rms=%0d", lvl, rms));
        return;
      end
      exp_r = expected_q.pop_front();
      results_checked++;
      if (exp_r.range_cleared) clears_seen++;
      level_hits[exp_r.level]++;
      if (lvl !== exp_r.level)
        report($sformatf("level %0d, predicted %0d (rms %0d)", lvl, exp_r.level,
                         exp_r.rms_value));
      if (rms !== exp_r.rms_value)
        report($sformatf("rms_value %0d, predicted %0d", rms, exp_r.rms_value));
      if (clr !== exp_r.range_cleared)
        report($sformatf("range_cleared %b, predicted %b", clr, exp_r.range_cleared));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [arms_pkg::LIM_W-1:0] cfg_wdata;
  bit                         gaps_on;
  int                         items_sent;
  int                         cycle_count;
  rms_meter_scoreboard        meter_sb = new();

  arms_in_if  in_ch ();
  arms_out_if out_ch ();

  auto_ranging_rms_level_meter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(bit op, logic signed [15:0] smp, bit last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.sample     <= smp;
    in_ch.chunk_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    meter_sb.note_item(op, smp, last);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  // Drop valid, wait for every pending result, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (meter_sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [arms_pkg::LIM_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    meter_sb.silence_limit = value;
  endtask

  // One chunk of random length and loudness, with a stray tick now and then
  task automatic send_random_chunk();
    int                 len;
    int                 shift;
    int                 style;
    logic signed [15:0] smp;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
    shift = $urandom_range(0, 15);
    style = $urandom_range(0, 15);
    for (int k = 0; k < len; k++) begin
      if (style == 0) smp = 16'sh8000;
      else if (style == 1) smp = 16'sh7FFF;
      else smp = 16'(($urandom & ((32'd2 << shift) - 1)) - (32'd1 << shift));
      if ($urandom_range(0, 19) == 0) send_ticks(1);
      send_item(OP_SAMPLE, smp, k == len - 1);
    end
  endtask

  task automatic run_random_phase(int n_items);
    int stop_at;
    int nt;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 5) != 0);
      send_random_chunk();
      // Silence between chunks: none, short, or right around the limit when that is at most 200
      case ($urandom_range(0, 9))
        0, 1, 2, 3: nt = 0;
        4, 5, 6, 7: nt = $urandom_range(1, 8);
        default: nt = (meter_sb.silence_limit <= 200) ?
                      int'(meter_sb.silence_limit) + $urandom_range(0, 2) :
                      $urandom_range(1, 30);
      endcase
      send_ticks(nt);
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  // Result side: stall a random number of cycles, or stay ready for a stretch
  initial begin
    int stall;
    bit always_ready;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall        = $urandom_range(0, 9);
      always_ready = ($urandom_range(0, 3) == 0);
      @(negedge clk);
      if (always_ready) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
        repeat (stall) @(negedge clk);
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      meter_sb.check_result(out_ch.level, out_ch.rms_value, out_ch.range_cleared);
    end
  end

  // Hard stop on a hang
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("[auto_ranging_rms_level_meter] ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_SAMPLE;
    in_ch.sample     = '0;
    in_ch.chunk_last = 1'b0;
    gaps_on          = 1'b1;
    items_sent       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, ticks inside a chunk, clear and zero span
    set_limit(16'd2);
    send_item(OP_TICK, 16'sh8000, 1'b1);
    send_item(OP_SAMPLE, 16'sd0, 1'b1);
    send_item(OP_SAMPLE, 16'sh7FFF, 1'b1);
    send_item(OP_SAMPLE, 16'sh4000, 1'b1);
    send_item(OP_SAMPLE, 16'sh8000, 1'b0);
    send_item(OP_TICK, 16'sh7FFF, 1'b0);
    send_item(OP_SAMPLE, 16'sh8000, 1'b1);
    send_item(OP_SAMPLE, 16'sd1, 1'b0);
    send_item(OP_SAMPLE, -16'sd1, 1'b1);
    send_ticks(3);
    send_item(OP_SAMPLE, -16'sd200, 1'b1);
    send_item(OP_SAMPLE, -16'sd200, 1'b1);
    send_ticks(2);
    send_item(OP_SAMPLE, 16'sd5, 1'b1);
    send_item(OP_SAMPLE, 16'sh7FFF, 1'b0);
    send_item(OP_SAMPLE, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'sh8000, 1'b1);
    send_item(OP_SAMPLE, 16'sh2AAA, 1'b1);

    // Overfull chunk of full-scale samples, ended by a sample past capacity
    gaps_on = 1'b0;
    for (int k = 0; k < FULL_CHUNK; k++) send_item(OP_SAMPLE, 16'sh8000, k == FULL_CHUNK - 1);

    // Saturate the idle counter against the largest limit
    set_limit(16'hFFFF);
    gaps_on = 1'b0;
    send_ticks(TICK_BURST);
    send_item(OP_SAMPLE, 16'sh0123, 1'b1);
    gaps_on = 1'b1;

    // Random chunks under several limits
    set_limit(16'd0);
    run_random_phase(RANDOM_ITEMS / 4);
    set_limit(16'd3000);
    run_random_phase(RANDOM_ITEMS / 4);
    set_limit(16'($urandom_range(1, 64)));
    run_random_phase(RANDOM_ITEMS / 4);
    set_limit(16'($urandom_range(65, 200)));
    run_random_phase(RANDOM_ITEMS / 4);

    wait_drained();
    $display("run covered %0d items, %0d chunk results, %0d range clears, %0d full-scale",
             items_sent, meter_sb.results_checked, meter_sb.clears_seen,
             meter_sb.saturated_seen);
    $display("results per level 0..5: %0d %0d %0d %0d %0d %0d; mismatches: %0d",
             meter_sb.level_hits[0], meter_sb.level_hits[1], meter_sb.level_hits[2],
             meter_sb.level_hits[3], meter_sb.level_hits[4], meter_sb.level_hits[5],
             meter_sb.errors);
    if (meter_sb.errors == 0) begin
      $display("[auto_ranging_rms_level_meter] OK");
    end else begin
      $display("[auto_ranging_rms_level_meter] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/arms_pkg.sv
sv/arms_in_if.sv
sv/arms_out_if.sv
sv/arms_sq.sv
sv/arms_div.sv
sv/arms_sqrt.sv
sv/arms_lvl.sv
sv/auto_ranging_rms_level_meter.sv
tb/tb_auto_ranging_rms_level_meter.sv
